// ===== rtl/status_packet_receiver_assert.svh =====
// Assertion macros shared by the status packet receiver RTL.
// Each macro expands to one labelled concurrent assertion clocked on clk.
`ifndef STATUS_PACKET_RECEIVER_ASSERT_SVH
`define STATUS_PACKET_RECEIVER_ASSERT_SVH

// Checked only outside reset.
`define SPR_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPR_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spr_pkg.sv =====
// Shared constants and types for the status packet receiver.
// No dependencies.
`timescale 1ns / 1ps

package spr_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_BODY   = 3'd1;
  localparam logic [2:0] KIND_GOOD   = 3'd2;
  localparam logic [2:0] KIND_BAD    = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;
  localparam logic [2:0] KIND_SHORT  = 3'd5;

  localparam logic [8:0] CNT_HDR2 = 9'd2;
  localparam logic [8:0] CNT_ID   = 9'd2;
  localparam logic [8:0] CNT_LEN  = 9'd3;
  localparam logic [8:0] CNT_INFO = 9'd4;
  localparam logic [8:0] CNT_TAIL = 9'd3;
  localparam logic [8:0] CNT_MAX  = 9'd258;

  localparam logic [7:0] LEN_MIN = 8'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] offset;
  } spr_result_t;

endpackage

// ===== rtl/status_packet_receiver.sv =====
// Status packet receiver: frame parser with registered, skid-buffered result.
// Depends on spr_pkg, spr_parser and spr_out_buf.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall carries one received serial byte per beat
//   on in_rx_byte. Every accepted byte yields exactly one result beat on
//   out_valid/out_stall with out_kind, out_data (the byte echoed) and
//   out_offset (position counted from the id byte).
//   cfg_we/cfg_wdata write the device id a frame must carry; write it only
//   while no beats are in flight.
//   The decoded result is registered, into the skid stage when the result
//   register is held. Throughput: one byte per cycle while in_stall is low,
//   set by the single decode stage between frame state and result registers.
//   Reset (rst_n low, synchronous) clears the device id to zero, returns the
//   parser to header hunting and empties the result path.
//   When the receiver stalls, the result register holds its beat and one
//   further beat lands in the skid stage; in_stall then rises until the
//   held result beat is taken.

module status_packet_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_data,
  output logic [7:0] out_offset
);

  spr_pkg::spr_result_t dec_res;
  spr_pkg::spr_result_t out_res;
  logic                 accept;

  assign accept = in_valid && !in_stall;

  spr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .res      (dec_res)
  );

  spr_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_res   (dec_res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_kind   = out_res.kind;
  assign out_data   = out_res.data;
  assign out_offset = out_res.offset;

endmodule

// ===== rtl/spr_parser.sv =====
// Frame tracking state and per-byte decode for the status packet receiver.
// Depends on spr_pkg and status_packet_receiver_assert.svh.
`timescale 1ns / 1ps
`include "status_packet_receiver_assert.svh"

module spr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output spr_pkg::spr_result_t res
);

  logic [7:0] device_id_r;
  logic [8:0] byte_count_r, byte_count_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [8:0] cnt_off;
  logic [8:0] body_end;
  logic       in_body;
  logic       len_ok;
  logic       frame_end;

  assign cnt_off  = byte_count_r - spr_pkg::CNT_HDR2;
  assign body_end = {1'b0, frame_length_r} + spr_pkg::CNT_TAIL;

  always_comb begin
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    running_sum_nxt  = running_sum_r;
    res.data         = rx_byte;
    res.offset       = 8'd0;
    res.kind         = spr_pkg::KIND_REJECT;
    if (byte_count_r < spr_pkg::CNT_HDR2) begin
      if (rx_byte == spr_pkg::HEADER_BYTE) begin
        byte_count_nxt = byte_count_r + 9'd1;
        res.kind       = spr_pkg::KIND_HEADER;
      end else begin
        byte_count_nxt   = 9'd0;
        frame_length_nxt = 8'd0;
        running_sum_nxt  = 8'd0;
        res.kind         = spr_pkg::KIND_REJECT;
      end
    end else if (byte_count_r == spr_pkg::CNT_ID) begin
      if (rx_byte == device_id_r) begin
        running_sum_nxt = rx_byte;
        byte_count_nxt  = spr_pkg::CNT_LEN;
        res.kind        = spr_pkg::KIND_BODY;
      end else begin
        byte_count_nxt   = 9'd0;
        frame_length_nxt = 8'd0;
        running_sum_nxt  = 8'd0;
        res.kind         = spr_pkg::KIND_REJECT;
      end
    end else if (byte_count_r == spr_pkg::CNT_LEN) begin
      res.offset = 8'd1;
      if (rx_byte < spr_pkg::LEN_MIN) begin
        byte_count_nxt   = 9'd0;
        frame_length_nxt = 8'd0;
        running_sum_nxt  = 8'd0;
        res.kind         = spr_pkg::KIND_SHORT;
      end else begin
        frame_length_nxt = rx_byte;
        running_sum_nxt  = running_sum_r + rx_byte;
        byte_count_nxt   = spr_pkg::CNT_INFO;
        res.kind         = spr_pkg::KIND_BODY;
      end
    end else if (byte_count_r < body_end) begin
      res.offset      = cnt_off[7:0];
      running_sum_nxt = running_sum_r + rx_byte;
      byte_count_nxt  = byte_count_r + 9'd1;
      res.kind        = spr_pkg::KIND_BODY;
    end else begin
      res.offset       = cnt_off[7:0];
      res.kind         = (rx_byte == ~running_sum_r) ? spr_pkg::KIND_GOOD : spr_pkg::KIND_BAD;
      byte_count_nxt   = 9'd0;
      frame_length_nxt = 8'd0;
      running_sum_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r    <= 8'd0;
      byte_count_r   <= 9'd0;
      frame_length_r <= 8'd0;
      running_sum_r  <= 8'd0;
    end else begin
      if (cfg_we) begin
        device_id_r <= cfg_wdata;
      end
      if (accept) begin
        byte_count_r   <= byte_count_nxt;
        frame_length_r <= frame_length_nxt;
        running_sum_r  <= running_sum_nxt;
      end
    end
  end

  assign in_body   = byte_count_r >= spr_pkg::CNT_INFO;
  assign len_ok    = frame_length_r >= spr_pkg::LEN_MIN;
  assign frame_end = accept && (res.kind == spr_pkg::KIND_GOOD || res.kind == spr_pkg::KIND_BAD);

  `SPR_ASSERT_CLK(a_count_bound, (byte_count_r <= spr_pkg::CNT_MAX), "byte count out of range")
  `SPR_ASSERT_CLK(a_len_valid, in_body |-> len_ok, "short frame length held in frame")
  `SPR_ASSERT_CLK(a_end_resync, frame_end |=> (byte_count_r == 9'd0), "no resync after checksum")

endmodule

// ===== rtl/spr_out_buf.sv =====
// Result register with skid stage for the status packet receiver.
// Depends on spr_pkg and status_packet_receiver_assert.svh.
`timescale 1ns / 1ps
`include "status_packet_receiver_assert.svh"

module spr_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spr_pkg::spr_result_t in_res,
  output logic                out_valid,
  input  logic                out_stall,
  output spr_pkg::spr_result_t out_res
);

  logic                 main_valid_r;
  logic                 skid_valid_r;
  spr_pkg::spr_result_t main_r;
  spr_pkg::spr_result_t skid_r;
  logic                 take_in;
  logic                 take_out;
  logic                 main_free;

  assign in_stall  = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;
  assign take_in   = in_valid && !skid_valid_r;
  assign take_out  = main_valid_r && !out_stall;
  assign main_free = !main_valid_r || take_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || take_in;
      skid_valid_r <= 1'b0;
    end else if (take_in) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_valid_r ? skid_r : in_res;
    end
    if (take_in && !main_free) begin
      skid_r <= in_res;
    end
  end

  `SPR_ASSERT_ALL(a_skid_needs_main, skid_valid_r |-> main_valid_r, "skid beat held without main beat")

endmodule

// ===== dv/status_packet_receiver_test.sv =====
// Self-checking testbench for status_packet_receiver: frame hunting, id match,
// length and checksum checks, with paced input beats and a stalling receiver.
// Depends on spr_pkg and the status_packet_receiver RTL.
`timescale 1ns / 1ps

module status_packet_receiver_test;

  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_kind;
  logic [7:0] out_data;
  logic [7:0] out_offset;

  status_packet_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_offset (out_offset)
  );

  spr_pkg::spr_result_t expected_status[$];
  logic [8:0]  frame_count = 9'd0;
  logic [7:0]  frame_len   = 8'd0;
  logic [7:0]  frame_sum   = 8'd0;
  logic [7:0]  id_setting  = 8'd0;

  int error_count = 0;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit pace_on     = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int mode_left   = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic restart_hunt();
    frame_count = 9'd0;
    frame_len   = 8'd0;
    frame_sum   = 8'd0;
  endtask

  task automatic predict_status(input logic [7:0] b);
    spr_pkg::spr_result_t r;
    logic [8:0]  pos;
    r.data   = b;
    r.offset = 8'd0;
    pos      = frame_count - 9'd2;
    if (frame_count < 9'd2) begin
      if (b == spr_pkg::HEADER_BYTE) begin
        frame_count = frame_count + 9'd1;
        r.kind = spr_pkg::KIND_HEADER;
      end else begin
        restart_hunt();
        r.kind = spr_pkg::KIND_REJECT;
      end
    end else if (frame_count == 9'd2) begin
      if (b == id_setting) begin
        frame_sum   = b;
        frame_count = 9'd3;
        r.kind = spr_pkg::KIND_BODY;
      end else begin
        restart_hunt();
        r.kind = spr_pkg::KIND_REJECT;
      end
    end else if (frame_count == 9'd3) begin
      r.offset = 8'd1;
      if (b < spr_pkg::LEN_MIN) begin
        restart_hunt();
        r.kind = spr_pkg::KIND_SHORT;
      end else begin
        frame_len   = b;
        frame_sum   = frame_sum + b;
        frame_count = 9'd4;
        r.kind = spr_pkg::KIND_BODY;
      end
    end else if (frame_count < {1'b0, frame_len} + 9'd3) begin
      r.offset    = pos[7:0];
      frame_sum   = frame_sum + b;
      frame_count = frame_count + 9'd1;
      r.kind = spr_pkg::KIND_BODY;
    end else begin
      r.offset = pos[7:0];
      r.kind   = (b == ~frame_sum) ? spr_pkg::KIND_GOOD : spr_pkg::KIND_BAD;
      restart_hunt();
    end
    expected_status.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_status(in_rx_byte);
  end

  always @(posedge clk) begin
    spr_pkg::spr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected result beat, kind", int'(out_kind), -1);
      end else begin
        want = expected_status.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", int'(out_kind), int'(want.kind));
        if (out_data !== want.data)
          report_mismatch("data", int'(out_data), int'(want.data));
        if (out_offset !== want.offset)
          report_mismatch("offset", int'(out_offset), int'(want.offset));
      end
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
      out_stall  <= 1'b0;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status_packet_receiver_test NOT OK");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (pace_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 30)) @(posedge clk);
        else repeat ($urandom_range(1, 4)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // keep < 0 sends the whole frame, otherwise only the first keep beats
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input bit corrupt, input int keep = -1);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         k;
    body = '{spr_pkg::HEADER_BYTE, spr_pkg::HEADER_BYTE, id, len};
    if (len >= spr_pkg::LEN_MIN) begin
      sum = id + len;
      for (k = 0; k < len - 1; k++) begin
        b = 8'($urandom_range(0, 255));
        sum = sum + b;
        body.push_back(b);
      end
      b = ~sum;
      if (corrupt) b = b ^ 8'($urandom_range(1, 255));
      body.push_back(b);
    end
    if (keep >= 0 && keep < body.size()) body = body[0:keep-1];
    for (k = 0; k < body.size(); k++) send_byte(body[k]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_device_id(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    id_setting  = value;
  endtask

  task automatic test_reset_id_frames();
    send_frame(8'h00, 8'd2, 1'b0);
    send_frame(8'h00, 8'd3, 1'b1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7E);
    send_frame(8'h42, 8'd4, 1'b0);
    send_frame(8'h00, 8'd0, 1'b0);
    send_frame(8'h00, 8'd1, 1'b0);
    wait_drain();
  endtask

  task automatic test_id_extremes();
    write_device_id(8'hFF);
    send_frame(8'hFF, 8'd3, 1'b0);
    send_frame(8'h00, 8'd2, 1'b0);
    send_frame(8'hFF, 8'hFE, 1'b0, 7);
    wait_drain();
    write_device_id(8'h5A);
    send_frame(8'hFF, 8'd2, 1'b0);
    send_frame(8'h5A, 8'd2, 1'b0);
    wait_drain();
  endtask

  task automatic test_longest_frame();
    write_device_id(8'($urandom_range(0, 255)));
    send_frame(id_setting, 8'd255, 1'b0);
    send_frame(id_setting, 8'd255, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_traffic(input logic [7:0] id, input int target);
    int         pick;
    int         n;
    logic [7:0] len;
    write_device_id(id);
    pace_on = 1;
    burst_left = $urandom_range(0, 20);
    target = bytes_sent + target;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) len = 8'($urandom_range(200, 255));
      else if ($urandom_range(0, 4) == 0) len = 8'($urandom_range(13, 40));
      else len = 8'($urandom_range(2, 12));
      if (pick < 62) begin
        send_frame(id_setting, len, 1'b0);
      end else if (pick < 74) begin
        send_frame(id_setting, len, 1'b1);
      end else if (pick < 80) begin
        send_frame(id_setting ^ 8'($urandom_range(1, 255)), len, 1'b0);
      end else if (pick < 85) begin
        send_frame(id_setting, 8'($urandom_range(0, 1)), 1'b0);
      end else if (pick < 92) begin
        send_frame(id_setting, len, 1'($urandom_range(0, 1)), $urandom_range(1, len + 2));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(($urandom_range(0, 3) == 0) ? spr_pkg::HEADER_BYTE
                                                          : 8'($urandom_range(0, 255)));
      end
    end
    pace_on = 0;
    wait_drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 8'h00;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    out_stall  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_id_frames();
    test_id_extremes();
    test_longest_frame();
    test_random_traffic(8'($urandom_range(1, 254)), 300);
    test_random_traffic(8'h00, 250);
    test_random_traffic(8'hFF, 250);
    test_random_traffic(8'($urandom_range(0, 255)), 350);

    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("status_packet_receiver_test OK");
    end else begin
      $display("status_packet_receiver_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== status_packet_receiver.f =====
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_parser.sv
rtl/spr_out_buf.sv
rtl/status_packet_receiver.sv
dv/status_packet_receiver_test.sv
